// ----- hdl/tcce_pkg.sv -----
// Shared types and constants for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int XW     = 12;
  localparam int YW     = 16;
  localparam int DIV_NW = 12;
  localparam int DIV_DW = 13;

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_COPY  = 2'd1,
    OP_FILL  = 2'd2,
    OP_GLYPH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_BOTTOM = 3'd3,
    REG_LINE_H = 3'd4,
    REG_SPACE  = 3'd5,
    REG_TAB    = 3'd6,
    REG_SCROLL = 3'd7
  } reg_e;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

// ----- hdl/tcce_div.sv -----
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module tcce_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcce_pkg::div_req_t  req_i,
  output tcce_pkg::div_rsp_t  rsp_o
);
  import tcce_pkg::*;

  localparam int CntW = $clog2(DIV_NW + 1);

  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_NW-1:0] num_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] rem_d;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;

  assign shifted = {rem_q, num_q[DIV_NW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign rem_d   = (shifted >= {1'b0, den_q}) ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else if (req_i.start) begin
      num_q  <= req_i.dividend;
      den_q  <= req_i.divisor;
      rem_q  <= '0;
      cnt_q  <= CntW'(DIV_NW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[DIV_NW-2:0], 1'b0};
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- hdl/tcce_hist.sv -----
// Backspace history memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tcce_hist #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [tcce_pkg::XW-1:0]      wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [tcce_pkg::XW-1:0]      rdata_o
);
  import tcce_pkg::*;

  logic [XW-1:0] mem_q [DEPTH];
  logic [XW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/text_console_cursor_engine.sv -----
// Text console cursor engine top level: sequencer, cursor state and output register.
//
// Usage: write the window and font registers through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle; writing win_left or win_top homes the cursor.
// Send one decoded character per item on the input channel (in_valid_i,
// in_stall_o). Each item yields one to four drawing commands on the output
// channel (out_valid_o, out_stall_i); last_o marks the final command of an item.
// Input stall is high from acceptance until the final command is loaded into
// the output register; the next item may be taken while that command waits.
// A tab makes two 12-step passes through the shared remainder unit, one for
// the space width and one for the tab span. An output stall holds the
// sequencer in its emitting state until the output register can take the command.
// Reset restores the register defaults, puts the cursor at (0, 0) and empties
// the history. A stalled command holds on the output ports until taken.
`timescale 1ns / 1ps

module text_console_cursor_engine #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic [7:0]         glyph_width_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         op_o,
  output logic [11:0]        rect_x0_o,
  output logic signed [15:0] rect_y0_o,
  output logic [11:0]        rect_x1_o,
  output logic signed [15:0] rect_y1_o,
  output logic signed [15:0] source_y_o,
  output logic [7:0]         glyph_code_o,
  output logic [11:0]        cursor_x_o,
  output logic signed [15:0] cursor_y_o,
  output logic               last_o
);
  import tcce_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_NL, S_CPY, S_FIL, S_NLFIN, S_TCHK, S_TDIV1, S_TWAIT1,
    S_TWAIT2, S_TFILL, S_GCHK, S_GFILL, S_GLYPH, S_BSFIL, S_EMIT0
  } state_e;

  typedef struct packed {
    op_e                  op;
    logic [XW-1:0]        x0;
    logic signed [YW-1:0] y0;
    logic [XW-1:0]        x1;
    logic signed [YW-1:0] y1;
    logic signed [YW-1:0] sy;
    logic [7:0]           g;
    logic [XW-1:0]        cx;
    logic signed [YW-1:0] cy;
    logic                 last;
  } out_t;

  function automatic logic [XW-1:0] sat_x(input logic [13:0] v);
    return (v > 14'd4095) ? 12'hFFF : v[XW-1:0];
  endfunction

  function automatic logic signed [YW-1:0] sat_y(input logic signed [18:0] v);
    if (v > 19'sd32767) return 16'sh7FFF;
    if (v < -19'sd32768) return 16'sh8000;
    return v[YW-1:0];
  endfunction

  function automatic out_t mk_out(input op_e op, input logic [XW-1:0] x0,
                                  input logic signed [YW-1:0] y0,
                                  input logic [XW-1:0] x1,
                                  input logic signed [YW-1:0] y1,
                                  input logic signed [YW-1:0] sy,
                                  input logic [7:0] g, input logic [XW-1:0] cx,
                                  input logic signed [YW-1:0] cy, input logic last);
    out_t o;
    o.op = op; o.x0 = x0; o.y0 = y0; o.x1 = x1; o.y1 = y1;
    o.sy = sy; o.g = g; o.cx = cx; o.cy = cy; o.last = last;
    return o;
  endfunction

  // configuration
  logic [11:0] left_q, top_q, right_q, bottom_q;
  logic [7:0]  lh_q, sw_q;
  logic [4:0]  ts_q;
  logic [6:0]  scroll_q;
  logic [14:0] off_q;
  logic [12:0] tsw_q;
  logic [7:0]  w_eff;
  logic [4:0]  ts_eff;

  assign w_eff  = (sw_q == 8'd0) ? 8'd1 : sw_q;
  assign ts_eff = (ts_q == 5'd0) ? 5'd1 : ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= 12'd0;
      top_q    <= 12'd0;
      right_q  <= 12'd1023;
      bottom_q <= 12'd767;
      lh_q     <= 8'd16;
      sw_q     <= 8'd8;
      ts_q     <= 5'd4;
      scroll_q <= 7'd8;
      off_q    <= 15'd128;
      tsw_q    <= 13'd32;
    end else begin
      off_q <= 15'(scroll_q) * 15'(lh_q);
      tsw_q <= 13'(ts_eff) * 13'(w_eff);
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_LEFT:   left_q   <= cfg_data_i;
          REG_TOP:    top_q    <= cfg_data_i;
          REG_RIGHT:  right_q  <= cfg_data_i;
          REG_BOTTOM: bottom_q <= cfg_data_i;
          REG_LINE_H: lh_q     <= cfg_data_i[7:0];
          REG_SPACE:  sw_q     <= cfg_data_i[7:0];
          REG_TAB:    ts_q     <= cfg_data_i[4:0];
          REG_SCROLL: scroll_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // sequencer state
  state_e               state_q;
  logic [XW-1:0]        x_q;
  logic signed [YW-1:0] y_q;
  logic [CW-1:0]        count_q;
  logic [7:0]           code_q, gw_q;
  logic [DIV_DW-1:0]    r2_q;
  logic [12:0]          adv_q;
  div_req_t             div_req_q;
  div_rsp_t             div_rsp;
  out_t                 out_q;
  logic                 out_valid_q;

  logic                 can_load;
  logic [CW-1:0]        count_eff, cnt_m1;
  logic signed [18:0]   ys, h19, bot19, top19, off19;
  logic signed [YW-1:0] y_plus_h, bot_m_off, top_p_off, y_m_off, top16, bot16;
  logic signed [YW-1:0] y_nl_fin;
  logic                 nl_cond, tab_wrap, gly_wrap;
  logic signed [14:0]   xs15;
  logic [XW-1:0]        x_plus_adv, x_plus_gw, x_rel;
  logic [13:0]          adv_sum;
  logic                 hist_we, hist_re;
  logic [XW-1:0]        hist_rdata;

  assign can_load  = !out_valid_q || !out_stall_i;
  assign count_eff = (count_q == CW'(HISTORY_DEPTH)) ? '0 : count_q;
  assign cnt_m1    = count_eff - CW'(1);

  assign ys    = 19'(y_q);
  assign h19   = {11'd0, lh_q};
  assign bot19 = {7'd0, bottom_q};
  assign top19 = {7'd0, top_q};
  assign off19 = {4'd0, off_q};
  assign top16 = {4'd0, top_q};
  assign bot16 = {4'd0, bottom_q};

  assign y_plus_h  = sat_y(ys + h19);
  assign bot_m_off = sat_y(bot19 - off19);
  assign top_p_off = sat_y(top19 + off19);
  assign y_m_off   = sat_y(ys - off19);
  assign y_nl_fin  = sat_y(19'(y_m_off) + h19);
  assign nl_cond   = (ys + h19) >= bot19;

  assign xs15     = {3'd0, x_q};
  assign tab_wrap = xs15 >= ($signed({3'd0, right_q}) - $signed({2'd0, tsw_q}));
  assign gly_wrap = xs15 >= ($signed({3'd0, right_q}) - $signed({7'd0, gw_q}));

  assign x_plus_adv = sat_x({2'd0, x_q} + {1'b0, adv_q});
  assign x_plus_gw  = sat_x({2'd0, x_q} + {6'd0, gw_q});
  assign x_rel      = x_q - left_q;
  // adv = tab_span - (d mod tab_span) + (d mod space_width)
  assign adv_sum    = {1'b0, tsw_q} - {1'b0, div_rsp.rem} + {1'b0, r2_q};

  assign hist_we = ((state_q == S_TFILL) || (state_q == S_GFILL)) && can_load;
  assign hist_re = (state_q == S_IDLE) && in_valid_i && (char_code_i == CH_BS) &&
                   (count_eff != '0);

  tcce_hist #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (x_q),
    .re_i    (hist_re),
    .raddr_i (cnt_m1[AW-1:0]),
    .rdata_o (hist_rdata)
  );

  tcce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      count_q     <= '0;
      code_q      <= '0;
      gw_q        <= '0;
      r2_q        <= '0;
      adv_q       <= '0;
      div_req_q   <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_we_i && (cfg_idx_i == REG_LEFT)) begin
            x_q <= cfg_data_i;
            y_q <= top16;
          end else if (cfg_we_i && (cfg_idx_i == REG_TOP)) begin
            x_q <= left_q;
            y_q <= {4'd0, cfg_data_i};
          end
          if (in_valid_i) begin
            code_q  <= char_code_i;
            gw_q    <= glyph_width_i;
            count_q <= count_eff;
            case (char_code_i)
              CH_NL:  state_q <= S_NL;
              CH_CR: begin
                x_q     <= left_q;
                count_q <= '0;
                state_q <= S_EMIT0;
              end
              CH_TAB: state_q <= S_TCHK;
              CH_BS: begin
                if (count_eff == '0) begin
                  state_q <= S_EMIT0;
                end else begin
                  count_q <= cnt_m1;
                  state_q <= S_BSFIL;
                end
              end
              CH_NUL: state_q <= S_EMIT0;
              default: state_q <= S_GCHK;
            endcase
          end
        end
        S_NL: state_q <= nl_cond ? S_CPY : S_NLFIN;
        S_CPY: begin
          if (can_load) begin
            out_q <= mk_out(OP_COPY, left_q, top16, right_q, bot_m_off, top_p_off,
                            8'd0, x_q, y_q, 1'b0);
            out_valid_q <= 1'b1;
            state_q     <= S_FIL;
          end
        end
        S_FIL: begin
          if (can_load) begin
            if (code_q == CH_NL) begin
              // plain newline: the fill closes the item with the final cursor
              out_q <= mk_out(OP_FILL, left_q, bot_m_off, right_q, bot16, '0,
                              8'd0, left_q, y_nl_fin, 1'b1);
              out_valid_q <= 1'b1;
              y_q         <= y_nl_fin;
              x_q         <= left_q;
              count_q     <= '0;
              state_q     <= S_IDLE;
            end else begin
              out_q <= mk_out(OP_FILL, left_q, bot_m_off, right_q, bot16, '0,
                              8'd0, x_q, y_q, 1'b0);
              out_valid_q <= 1'b1;
              y_q         <= y_m_off;
              state_q     <= S_NLFIN;
            end
          end
        end
        S_NLFIN: begin
          y_q     <= y_plus_h;
          x_q     <= left_q;
          count_q <= '0;
          if (code_q == CH_NL) begin
            state_q <= S_EMIT0;
          end else if (code_q == CH_TAB) begin
            state_q <= S_TDIV1;
          end else begin
            state_q <= S_GFILL;
          end
        end
        S_TCHK: state_q <= tab_wrap ? S_NL : S_TDIV1;
        S_TDIV1: begin
          div_req_q.start    <= 1'b1;
          div_req_q.dividend <= x_rel;
          div_req_q.divisor  <= {5'd0, w_eff};
          state_q            <= S_TWAIT1;
        end
        S_TWAIT1: begin
          if (div_rsp.done) begin
            r2_q               <= div_rsp.rem;
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= x_rel;
            div_req_q.divisor  <= tsw_q;
            state_q            <= S_TWAIT2;
          end
        end
        S_TWAIT2: begin
          if (div_rsp.done) begin
            adv_q   <= adv_sum[12:0];
            state_q <= S_TFILL;
          end
        end
        S_TFILL: begin
          if (can_load) begin
            out_q <= mk_out(OP_FILL, x_q, y_q, x_plus_adv, y_plus_h, '0,
                            8'd0, x_plus_adv, y_q, 1'b1);
            out_valid_q <= 1'b1;
            x_q         <= x_plus_adv;
            count_q     <= count_q + CW'(1);
            state_q     <= S_IDLE;
          end
        end
        S_GCHK: state_q <= gly_wrap ? S_NL : S_GFILL;
        S_GFILL: begin
          if (can_load) begin
            out_q <= mk_out(OP_FILL, x_q, y_q, x_plus_gw, y_plus_h, '0,
                            8'd0, x_q, y_q, 1'b0);
            out_valid_q <= 1'b1;
            count_q     <= count_q + CW'(1);
            state_q     <= S_GLYPH;
          end
        end
        S_GLYPH: begin
          if (can_load) begin
            out_q <= mk_out(OP_GLYPH, x_q, y_q, x_plus_gw, y_plus_h, '0,
                            code_q, x_plus_gw, y_q, 1'b1);
            out_valid_q <= 1'b1;
            x_q         <= x_plus_gw;
            state_q     <= S_IDLE;
          end
        end
        S_BSFIL: begin
          if (can_load) begin
            out_q <= mk_out(OP_FILL, hist_rdata, y_q, x_q, y_plus_h, '0,
                            8'd0, hist_rdata, y_q, 1'b1);
            out_valid_q <= 1'b1;
            x_q         <= hist_rdata;
            state_q     <= S_IDLE;
          end
        end
        S_EMIT0: begin
          if (can_load) begin
            out_q <= mk_out(OP_NONE, '0, '0, '0, '0, '0, 8'd0, x_q, y_q, 1'b1);
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign op_o         = out_q.op;
  assign rect_x0_o    = out_q.x0;
  assign rect_y0_o    = out_q.y0;
  assign rect_x1_o    = out_q.x1;
  assign rect_y1_o    = out_q.y1;
  assign source_y_o   = out_q.sy;
  assign glyph_code_o = out_q.g;
  assign cursor_x_o   = out_q.cx;
  assign cursor_y_o   = out_q.cy;
  assign last_o       = out_q.last;

endmodule

// ----- verif/tb_text_console_cursor_engine.sv -----
// Self-checking testbench for the text console cursor engine: directed and random characters.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int STACK_SIZE = 256;

  typedef struct packed {
    op_e         op;
    logic [11:0] x0;
    logic [15:0] y0;
    logic [11:0] x1;
    logic [15:0] y1;
    logic [15:0] src_y;
    logic [7:0]  glyph;
    logic [11:0] cx;
    logic [15:0] cy;
    logic        last;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] width;
  } char_item_t;

  typedef struct packed {
    reg_e        idx;
    logic [11:0] val;
  } reg_write_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [11:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_code_i = '0;
  logic [7:0]         glyph_width_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         op_o;
  logic [11:0]        rect_x0_o;
  logic signed [15:0] rect_y0_o;
  logic [11:0]        rect_x1_o;
  logic signed [15:0] rect_y1_o;
  logic signed [15:0] source_y_o;
  logic [7:0]         glyph_code_o;
  logic [11:0]        cursor_x_o;
  logic signed [15:0] cursor_y_o;
  logic               last_o;

  text_console_cursor_engine uut (.*);

  // cursor and window shadow
  int left_px, top_px, right_px, bottom_px;
  int line_px, space_px, tab_stops, scroll_rows;
  int col_px, row_px;
  int x_stack [STACK_SIZE];
  int stack_depth;

  draw_cmd_t  step_cmds [4];
  int         step_n;
  draw_cmd_t  pending_draws [$];
  char_item_t char_queue [$];
  reg_write_t reg_writes [$];

  int   mismatch_count = 0;
  int   send_pct = 0;
  int   recv_pct = 0;
  logic hold_in = 1'b0;
  logic hold_out = 1'b0;
  logic in_fire = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int sat_x(int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  function automatic int sat_y(int v);
    return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
  endfunction

  task automatic add_cmd(op_e op, int x0, int y0, int x1, int y1, int sy, logic [7:0] g);
    if (step_n < 4) begin
      step_cmds[step_n].op    = op;
      step_cmds[step_n].x0    = 12'(sat_x(x0));
      step_cmds[step_n].y0    = 16'(sat_y(y0));
      step_cmds[step_n].x1    = 12'(sat_x(x1));
      step_cmds[step_n].y1    = 16'(sat_y(y1));
      step_cmds[step_n].src_y = 16'(sat_y(sy));
      step_cmds[step_n].glyph = g;
      step_cmds[step_n].cx    = 12'(col_px);
      step_cmds[step_n].cy    = 16'(row_px);
      step_cmds[step_n].last  = 1'b0;
      step_n++;
    end
  endtask

  task automatic return_home();
    stack_depth = 0;
    col_px = left_px;
  endtask

  task automatic line_feed();
    int o;
    o = scroll_rows * line_px;
    if (row_px + line_px >= bottom_px) begin
      add_cmd(OP_COPY, left_px, top_px, right_px, bottom_px - o, top_px + o, 8'd0);
      add_cmd(OP_FILL, left_px, bottom_px - o, right_px, bottom_px, 0, 8'd0);
      row_px = sat_y(row_px - o);
    end
    row_px = sat_y(row_px + line_px);
    return_home();
  endtask

  task automatic push_col();
    if (stack_depth < STACK_SIZE) begin
      x_stack[stack_depth] = col_px & 12'hFFF;
      stack_depth++;
    end
  endtask

  task automatic track_char(logic [7:0] code, logic [7:0] gw8);
    int gw, w, ts, d, q, adv, px;
    gw = int'(gw8);
    step_n = 0;
    if (stack_depth >= STACK_SIZE) stack_depth = 0;
    case (code)
      CH_NL: line_feed();
      CH_CR: return_home();
      CH_TAB: begin
        w = (space_px == 0) ? 1 : space_px;
        ts = (tab_stops == 0) ? 1 : tab_stops;
        if (col_px >= right_px - ts * w) line_feed();
        d = (col_px - left_px) & 32'hFFF;
        q = d / w;
        adv = (ts - q % ts) * w;
        push_col();
        add_cmd(OP_FILL, col_px, row_px, col_px + adv, row_px + line_px, 0, 8'd0);
        col_px = sat_x(col_px + adv);
      end
      CH_BS: begin
        if (stack_depth != 0) begin
          stack_depth--;
          px = x_stack[stack_depth];
          add_cmd(OP_FILL, px, row_px, col_px, row_px + line_px, 0, 8'd0);
          col_px = px;
        end
      end
      CH_NUL: ;
      default: begin
        if (col_px >= right_px - gw) line_feed();
        push_col();
        add_cmd(OP_FILL, col_px, row_px, col_px + gw, row_px + line_px, 0, 8'd0);
        add_cmd(OP_GLYPH, col_px, row_px, col_px + gw, row_px + line_px, 0, code);
        col_px = sat_x(col_px + gw);
      end
    endcase
    if (step_n == 0) add_cmd(OP_NONE, 0, 0, 0, 0, 0, 8'd0);
    step_cmds[step_n - 1].cx   = 12'(col_px);
    step_cmds[step_n - 1].cy   = 16'(row_px);
    step_cmds[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) pending_draws.push_back(step_cmds[i]);
  endtask

  task automatic set_reg(reg_e idx, logic [11:0] v);
    case (idx)
      REG_LEFT:   left_px = int'(v);
      REG_TOP:    top_px = int'(v);
      REG_RIGHT:  right_px = int'(v);
      REG_BOTTOM: bottom_px = int'(v);
      REG_LINE_H: line_px = int'(v[7:0]);
      REG_SPACE:  space_px = int'(v[7:0]);
      REG_TAB:    tab_stops = int'(v[4:0]);
      REG_SCROLL: scroll_rows = int'(v[6:0]);
      default: ;
    endcase
    if (idx == REG_LEFT || idx == REG_TOP) begin
      col_px = left_px;
      row_px = top_px;
    end
  endtask

  task automatic note_error(string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) note_error($sformatf("%s got 0x%h expected 0x%h", name, got, want));
  endtask

  task automatic check_cmd();
    draw_cmd_t want;
    if (pending_draws.size() == 0) begin
      note_error($sformatf("unexpected command op=%0d", op_o));
      return;
    end
    want = pending_draws.pop_front();
    compare_field("op", 16'(op_o), 16'(want.op));
    compare_field("rect_x0", 16'(rect_x0_o), 16'(want.x0));
    compare_field("rect_y0", rect_y0_o, want.y0);
    compare_field("rect_x1", 16'(rect_x1_o), 16'(want.x1));
    compare_field("rect_y1", rect_y1_o, want.y1);
    compare_field("source_y", source_y_o, want.src_y);
    compare_field("glyph_code", 16'(glyph_code_o), 16'(want.glyph));
    compare_field("cursor_x", 16'(cursor_x_o), 16'(want.cx));
    compare_field("cursor_y", cursor_y_o, want.cy);
    compare_field("last", 16'(last_o), 16'(want.last));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) check_cmd();
      if (in_valid_i && !in_stall_o) track_char(char_code_i, glyph_width_i);
    end
  end

  always @(negedge clk_i) begin
    char_item_t nxt;
    out_stall_i <= hold_out || ($urandom_range(99) < recv_pct);
    if (!in_valid_i || in_fire) begin
      if (char_queue.size() != 0 && !hold_in && $urandom_range(99) >= send_pct) begin
        nxt = char_queue.pop_front();
        in_valid_i    <= 1'b1;
        char_code_i   <= nxt.code;
        glyph_width_i <= nxt.width;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic add_char(logic [7:0] code, logic [7:0] width);
    char_queue.push_back('{code, width});
  endtask

  task automatic add_random_char();
    int pick;
    logic [7:0] code, wd;
    pick = $urandom_range(99);
    if (pick < 12) code = CH_NL;
    else if (pick < 20) code = CH_CR;
    else if (pick < 32) code = CH_TAB;
    else if (pick < 46) code = CH_BS;
    else if (pick < 50) code = CH_NUL;
    else code = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 60) wd = 8'($urandom_range(24));
    else if (pick < 90) wd = 8'($urandom_range(255));
    else wd = (pick < 95) ? 8'd0 : 8'd255;
    add_char(code, wd);
  endtask

  task automatic flush_regs();
    reg_write_t wr;
    while (reg_writes.size() != 0) begin
      wr = reg_writes.pop_front();
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= wr.idx;
      cfg_data_i <= wr.val;
      set_reg(wr.idx, wr.val);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_window(int l, int t, int r, int b, int lh, int sw, int ts, int sc);
    reg_writes.push_back('{REG_LEFT, 12'(l)});
    reg_writes.push_back('{REG_TOP, 12'(t)});
    reg_writes.push_back('{REG_RIGHT, 12'(r)});
    reg_writes.push_back('{REG_BOTTOM, 12'(b)});
    reg_writes.push_back('{REG_LINE_H, 12'(lh)});
    reg_writes.push_back('{REG_SPACE, 12'(sw)});
    reg_writes.push_back('{REG_TAB, 12'(ts)});
    reg_writes.push_back('{REG_SCROLL, 12'(sc)});
    flush_regs();
  endtask

  task automatic program_random_window();
    int l, t;
    l = $urandom_range(1500);
    t = $urandom_range(1000);
    program_window(l, t, l + $urandom_range(50, 2500), t + $urandom_range(30, 3000),
                   $urandom_range(1, 40), $urandom_range(30), $urandom_range(16),
                   $urandom_range(1, 64));
  endtask

  task automatic drain();
    while (char_queue.size() != 0 || in_valid_i || pending_draws.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int mode;
    left_px = 0; top_px = 0; right_px = 1023; bottom_px = 767;
    line_px = 16; space_px = 8; tab_stops = 4; scroll_rows = 8;
    col_px = 0; row_px = 0; stack_depth = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset window: empty cases, every code, wrap
    add_char(CH_NUL, 8'd0);
    add_char(CH_BS, 8'd0);
    add_char(CH_CR, 8'd0);
    add_char(CH_NL, 8'd0);
    add_char(8'd65, 8'd0);
    add_char(8'd255, 8'd255);
    add_char(8'd1, 8'd8);
    add_char(CH_TAB, 8'd0);
    add_char(CH_BS, 8'd0);
    add_char(CH_BS, 8'd0);
    add_char(CH_TAB, 8'd255);
    repeat (3) add_char(8'd127, 8'd255);
    add_char(CH_NUL, 8'd255);
    drain();

    // moving the left edge puts the stored x left of the window
    reg_writes.push_back('{REG_LEFT, 12'd600});
    flush_regs();
    add_char(CH_BS, 8'd0);
    add_char(CH_TAB, 8'd0);
    drain();

    // short window: scroll, wrap plus scroll, zero tab and space width
    reg_writes.push_back('{REG_BOTTOM, 12'd40});
    reg_writes.push_back('{REG_LINE_H, 12'd16});
    reg_writes.push_back('{REG_SCROLL, 12'd1});
    reg_writes.push_back('{REG_SPACE, 12'd0});
    reg_writes.push_back('{REG_TAB, 12'd0});
    flush_regs();
    repeat (3) add_char(CH_NL, 8'd0);
    add_char(8'd200, 8'd255);
    add_char(8'd200, 8'd255);
    add_char(CH_TAB, 8'd0);
    add_char(CH_BS, 8'd255);
    add_char(CH_CR, 8'd0);
    drain();

    // wide window at the top extremes; x history wraps around
    send_pct = 0; recv_pct = 0;
    program_window(0, 4095, 4095, 4095, 255, 255, 31, 127);
    repeat (260) add_char(8'($urandom_range(32, 255)), 8'($urandom_range(1)));
    repeat (6) add_char(CH_BS, 8'($urandom_range(255)));
    repeat (30) add_random_char();
    drain();

    // low extremes
    send_pct = 84; recv_pct = 0;
    program_window(4095, 4095, 0, 0, 1, 0, 0, 1);
    repeat (40) add_random_char();
    drain();

    // small window under a long output hold-off
    send_pct = 0; recv_pct = 84;
    program_window(100, 50, 300, 200, 12, 6, 3, 2);
    fork
      begin
        hold_out = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_out = 1'b0;
      end
    join_none
    repeat (60) add_random_char();
    drain();

    // sender pauses until every command has come out
    send_pct = 8; recv_pct = 8;
    program_random_window();
    repeat (30) add_random_char();
    while (char_queue.size() != 0) @(posedge clk_i);
    hold_in = 1'b1;
    while (in_valid_i || pending_draws.size() != 0) @(posedge clk_i);
    hold_in = 1'b0;
    repeat (30) add_random_char();
    drain();

    mode = $urandom_range(3);
    send_pct = (mode == 1) ? 84 : ((mode == 3) ? 8 : 0);
    recv_pct = (mode == 2) ? 84 : ((mode == 3) ? 8 : 0);
    program_random_window();
    repeat (40) add_random_char();
    drain();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tcce_pkg.sv
hdl/tcce_div.sv
hdl/tcce_hist.sv
hdl/text_console_cursor_engine.sv
verif/tb_text_console_cursor_engine.sv
